### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the keypad decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle leads to another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/kpd_pkg.sv
// Shared types, character codes and lookup functions of the keypad decoder.
`default_nettype none

package kpd_pkg;

    // Configuration address width: one register word plus one beyond it
    localparam int KPD_ADDR_W = 3;
    localparam int KPD_DATA_W = 32;

    // Reset value of the error character ('$')
    localparam logic [7:0] KPD_ERROR_CHAR_RST = 8'h24;

    // Control and base characters
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_BAR   = 8'h7C;  // '|'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_A     = 8'h61;  // 'a'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Press count saturates here: more than four presses
    localparam logic [2:0] RUN_SAT = 3'd5;

    // Pending run and mode flags
    typedef struct packed {
        logic [3:0] digit;
        logic [2:0] count;
        logic       caps_on;
        logic       escape_pending;
    } t_run_state;

    // One result item
    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       bad_code;
        logic       is_last;
    } t_result;

    // Offset of the first letter of each letter key from 'a'
    function automatic logic [4:0] letter_base(input logic [3:0] digit);
        logic [4:0] base;
        case (digit)
            4'd3:    base = 5'd3;
            4'd4:    base = 5'd6;
            4'd5:    base = 5'd9;
            4'd6:    base = 5'd12;
            4'd7:    base = 5'd15;
            4'd8:    base = 5'd19;
            4'd9:    base = 5'd22;
            default: base = 5'd0;
        endcase
        return base;
    endfunction

    // Punctuation of key 1 for one to four presses
    function automatic logic [7:0] punct_char(input logic [1:0] press_idx);
        logic [7:0] ch;
        case (press_idx)
            2'd0:    ch = 8'h2E;  // '.'
            2'd1:    ch = 8'h2C;  // ','
            2'd2:    ch = 8'h21;  // '!'
            default: ch = 8'h3F;  // '?'
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### rtl/core/multitap_keypad_decoder.sv
// Multitap keypad text decoder: top level with input and result registers.
//
// Input channel: i_valid / o_ready carry one symbol byte and an end-of-message
// flag per transfer. Result channel: o_valid / i_ready carry one decoded
// character with has_char, bad_code and is_last flags.
// Each input transfer yields zero or one result: repeated digits only grow the
// pending run, ignored bytes yield nothing, and the end marker always yields
// exactly one result with is_last set.
// A symbol waits in the input register while the decode logic forms its
// result, which the result register loads once it is free or draining.
// Throughput: one symbol per cycle while the receiver takes results; the
// single decode stage between the two registers sets this rate.
// When the receiver stalls, the result register holds its item and the input
// register fills; o_ready drops only once both are occupied.
// Reset (synchronous, active low) empties both registers, clears the pending
// run, caps and escape flags, and sets the error character to '$'.
// The error character is written over the APB port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
`default_nettype none

module multitap_keypad_decoder
    import kpd_pkg::*;
#(
    parameter int ADDR_W = KPD_ADDR_W
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [7:0]            i_symbol,
    input  wire logic                  i_end_of_message,
    // result channel
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [7:0]                 o_char_code,
    output logic                       o_has_char,
    output logic                       o_bad_code,
    output logic                       o_is_last,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [KPD_DATA_W-1:0] pwdata,
    output logic [KPD_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic       r_in_valid;
    logic [7:0] r_symbol;
    logic       r_eom;
    t_run_state r_state;
    logic       r_out_valid;
    t_result    r_result;

    t_run_state n_state;
    t_result    n_result;
    logic       n_emit;
    logic       out_free;
    logic       advance;
    logic [7:0] error_char;

    kpd_apb #(
        .ADDR_W (ADDR_W)
    ) u_apb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_error_char (error_char)
    );

    kpd_decode u_decode (
        .i_symbol         (r_symbol),
        .i_end_of_message (r_eom),
        .i_state          (r_state),
        .i_error_char     (error_char),
        .o_state          (n_state),
        .o_emit           (n_emit),
        .o_result         (n_result)
    );

    // Advance the stage when the result register is free or draining
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    // Hold the accepted symbol
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_symbol <= i_symbol;
            r_eom    <= i_end_of_message;
        end
    end

    // Update run state and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= advance && n_emit;
            end
        end
        if (advance && n_emit) begin
            r_result <= n_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_char_code = r_result.char_code;
    assign o_has_char  = r_result.has_char;
    assign o_bad_code  = r_result.bad_code;
    assign o_is_last   = r_result.is_last;

endmodule

`default_nettype wire

### rtl/core/kpd_decode.sv
// Next-state and result logic for one symbol of the keypad decoder.
`default_nettype none

module kpd_decode
    import kpd_pkg::*;
(
    input  wire logic [7:0] i_symbol,
    input  wire logic       i_end_of_message,
    input  wire t_run_state i_state,
    input  wire logic [7:0] i_error_char,
    output t_run_state      o_state,
    output logic            o_emit,
    output t_result         o_result
);

    logic       is_digit;
    logic [3:0] sym_digit;
    logic [7:0] dec_char;
    logic       dec_bad;
    logic [2:0] max_press;
    logic [7:0] letter;
    logic [2:0] press_idx;

    assign is_digit  = (i_symbol >= CH_ZERO) && (i_symbol <= CH_NINE);
    assign sym_digit = 4'(i_symbol - CH_ZERO);
    assign press_idx = i_state.count - 3'd1;

    // Decode the pending run into a character
    always_comb begin
        max_press = ((i_state.digit == 4'd7) || (i_state.digit == 4'd9)) ? 3'd4 : 3'd3;
        letter    = CH_A + {3'b000, letter_base(i_state.digit)} + {5'b00000, press_idx};
        if (i_state.caps_on) begin
            letter = letter - CASE_OFS;
        end
        dec_char = i_error_char;
        dec_bad  = 1'b1;
        if ((i_state.digit >= 4'd2) && (i_state.digit <= 4'd9)) begin
            if ((i_state.count != 3'd0) && (i_state.count <= max_press)) begin
                dec_char = letter;
                dec_bad  = 1'b0;
            end
        end else if (i_state.digit == 4'd1) begin
            if ((i_state.count != 3'd0) && (i_state.count <= 3'd4)) begin
                dec_char = punct_char(press_idx[1:0]);
                dec_bad  = 1'b0;
            end
        end else if (i_state.digit == 4'd0) begin
            if (i_state.count == 3'd1) begin
                dec_char = CH_SPACE;
                dec_bad  = 1'b0;
            end
        end
    end

    // Update the run and flags, and form the result
    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        o_result = '0;
        if (i_end_of_message) begin
            // end marker: flush or report empty, then start a fresh message
            o_emit = 1'b1;
            if (i_state.count != 3'd0) begin
                o_result = '{char_code: dec_char, has_char: 1'b1,
                             bad_code: dec_bad, is_last: 1'b1};
            end else begin
                o_result = '{char_code: 8'h00, has_char: 1'b0,
                             bad_code: 1'b0, is_last: 1'b1};
            end
            o_state = '0;
        end else if (i_state.escape_pending) begin
            // pass the byte through raw
            o_state.escape_pending = 1'b0;
            o_emit   = 1'b1;
            o_result = '{char_code: i_symbol, has_char: 1'b1,
                         bad_code: 1'b0, is_last: 1'b0};
        end else if ((i_symbol == CH_HASH) || (i_symbol == CH_BAR)
                     || (i_symbol == CH_STAR)
                     || (is_digit && !((i_state.count != 3'd0)
                                       && (sym_digit == i_state.digit)))) begin
            // flush the pending run, if any
            if (i_state.count != 3'd0) begin
                o_emit   = 1'b1;
                o_result = '{char_code: dec_char, has_char: 1'b1,
                             bad_code: dec_bad, is_last: 1'b0};
            end
            o_state.count = 3'd0;
            o_state.digit = 4'd0;
            if (i_symbol == CH_HASH) begin
                o_state.caps_on = !i_state.caps_on;
            end
            if (i_symbol == CH_STAR) begin
                o_state.escape_pending = 1'b1;
            end
            if (is_digit) begin
                o_state.digit = sym_digit;
                o_state.count = 3'd1;
            end
        end else if (is_digit) begin
            // same digit again: extend the run, saturating
            if (i_state.count < RUN_SAT) begin
                o_state.count = i_state.count + 3'd1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/kpd_apb.sv
// APB configuration register of the keypad decoder: the error character.
`default_nettype none

module kpd_apb
    import kpd_pkg::*;
#(
    parameter int ADDR_W = KPD_ADDR_W
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [KPD_DATA_W-1:0] pwdata,
    output logic [KPD_DATA_W-1:0]      prdata,
    output logic                       pready,
    output logic [7:0]                 o_error_char
);

    logic [7:0] r_error_char;
    logic       sel_err;

    // Register 0 sits at word address zero
    assign sel_err = (paddr[ADDR_W-1:2] == '0);
    assign pready  = 1'b1;

    // Write the error character on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_char <= KPD_ERROR_CHAR_RST;
        end else if (psel && penable && pwrite && sel_err) begin
            r_error_char <= pwdata[7:0];
        end
    end

    // Read back
    assign prdata       = sel_err ? {{(KPD_DATA_W-8){1'b0}}, r_error_char} : '0;
    assign o_error_char = r_error_char;

endmodule

`default_nettype wire

### rtl/core/kpd_checker.sv
// Port-level checks of the keypad decoder, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module kpd_checker
    import kpd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_char_code,
    input wire logic       o_has_char,
    input wire logic       o_bad_code,
    input wire logic       o_is_last
);

    // An empty result only answers the end marker and carries a zero byte
    `ASSERT_ALWAYS(a_empty_is_last, i_clk, i_rst_n, !(o_valid && !o_has_char) || (o_is_last && o_char_code == 8'h00 && !o_bad_code), "empty result must be a zero end flush")

    // A bad code always comes with a character
    `ASSERT_ALWAYS(a_bad_has_char, i_clk, i_rst_n, !(o_valid && o_bad_code) || o_has_char, "bad code without a character")

    // A stalled result stays in place
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_char_code) && $stable(o_has_char) && $stable(o_bad_code) && $stable(o_is_last), "stalled result changed")

endmodule

bind multitap_keypad_decoder kpd_checker u_kpd_checker (.*);

`default_nettype wire
